### design/radar_measurement_jacobian_macros.svh
// ----------------------------------------------------------------------------
// Radar measurement Jacobian assertion macros
// Shorthand for the clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef RADAR_MEASUREMENT_JACOBIAN_MACROS_SVH
`define RADAR_MEASUREMENT_JACOBIAN_MACROS_SVH

// Same-cycle implication, sampled on the rising edge and switched off in reset.
`define RMJ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("radar jacobian check failed");

// Next-cycle implication, sampled on the rising edge and switched off in reset.
`define RMJ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("radar jacobian check failed");

`endif

### design/rmj_pkg.sv
// ----------------------------------------------------------------------------
// Radar measurement Jacobian package
// Beat types, pipeline depths and the output saturation function.
// ----------------------------------------------------------------------------
package rmj_pkg;

    localparam int WORD_W  = 32;
    localparam int ROOT_W  = 32;
    localparam int SUM_W   = 64;
    localparam int WIDE_W  = 96;

    localparam logic [WORD_W-1:0] MIN_RANGE_SQ_RESET = 32'd429497;

    localparam int FRONT_STAGES = 5;
    localparam int ROOT_STAGES  = ROOT_W;
    localparam int PROD_STAGES  = 2;
    localparam int DIV_STAGES   = WORD_W + 1;
    // Clock edges from the accepting edge to the edge that takes the result.
    localparam int PIPE_DEPTH   = 1 + FRONT_STAGES + ROOT_STAGES + PROD_STAGES
                                  + DIV_STAGES + 1;

    typedef struct packed {
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [WORD_W-1:0] vel_x;
        logic signed [WORD_W-1:0] vel_y;
    } jac_in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] range_by_px;
        logic signed [WORD_W-1:0] range_by_py;
        logic signed [WORD_W-1:0] bearing_by_px;
        logic signed [WORD_W-1:0] bearing_by_py;
        logic signed [WORD_W-1:0] rate_by_px;
        logic signed [WORD_W-1:0] rate_by_py;
        logic                     near_origin;
    } jac_out_t;

    // Sign and magnitude form of one item after the front end.
    typedef struct packed {
        logic [WORD_W-1:0] mag_x;
        logic [WORD_W-1:0] mag_y;
        logic              neg_x;
        logic              neg_y;
        logic              neg_d;
        logic              near;
        logic [SUM_W-1:0]  sum_sq;
        logic [SUM_W-1:0]  mag_d;
    } front_t;

    typedef struct packed {
        front_t            side;
        logic [ROOT_W-1:0] root;
        logic [WIDE_W-1:0] rho_cube;
        logic [WIDE_W-1:0] num_x3;
        logic [WIDE_W-1:0] num_y3;
    } prod_t;

    // Signs and the near flag that ride alongside the dividers.
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic neg_d;
        logic near;
    } side_t;

    function automatic logic [WORD_W-1:0] sat_q(input logic neg,
                                                input logic [WORD_W-1:0] q,
                                                input logic ovf);
        logic [WORD_W-1:0] r;
        if (ovf || q[WORD_W-1])
            r = neg ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        else
            r = neg ? (~q + 1'b1) : q;
        return r;
    endfunction

endpackage

### design/radar_measurement_jacobian.sv
// ----------------------------------------------------------------------------
// Radar measurement Jacobian
// Fixed-point Jacobian of the radar measurement for an extended Kalman filter.
// ----------------------------------------------------------------------------
// An item is a state beat (pos_x, pos_y, vel_x, vel_y) on state_vec, taken at
// a rising edge where start is high and busy is low. Each item gives exactly
// one result beat on jacobian, marked by done for a single cycle; the receiver
// cannot hold it off, so the pipeline never stalls.
// Each item passes the input register, five front-end stages, 32 square-root
// stages, two product stages, 33 divider stages and the output register.
// A new item may be taken at every edge, so the sustained rate is one item a
// cycle; every stage is registered and no stage ever waits on another.
// The one configuration register, the near-origin threshold on range squared,
// is written through cfg_wr_en and cfg_wr_data. Write it only while no item is
// in flight; this is not checked. Reset clears all valid bits and sets the
// threshold to 0.0001; busy is high till the first edge after reset, then low.
// ----------------------------------------------------------------------------
module radar_measurement_jacobian #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  rmj_pkg::jac_in_t              state_vec,
    output logic                          done,
    output rmj_pkg::jac_out_t             jacobian,
    input  logic                          cfg_wr_en,
    input  logic [rmj_pkg::WORD_W-1:0]    cfg_wr_data
);
    import rmj_pkg::*;

    // Numerator widths follow from the fraction width; denominators are fixed.
    localparam int NUM_R_W = WORD_W + FRAC_BITS;
    localparam int NUM_B_W = WORD_W + 2 * FRAC_BITS;
    localparam int NUM_C_W = WIDE_W + FRAC_BITS;

    // Control and configuration.
    logic              busy_reg, busy_next;
    logic [WORD_W-1:0] min_range_sq_reg, min_range_sq_next;
    logic              accept;

    // Input capture stage.
    logic    in_valid_reg;
    jac_in_t in_reg;

    // Between the blocks.
    logic              front_valid;
    front_t            front_data;
    logic              root_valid;
    front_t            root_side;
    logic [ROOT_W-1:0] root;
    logic              prod_valid;
    prod_t             prod;

    // Divider numerators, quotients and overflow flags.
    logic [NUM_R_W-1:0] num_rx, num_ry;
    logic [NUM_B_W-1:0] num_bx, num_by;
    logic [NUM_C_W-1:0] num_cx, num_cy;
    logic [WORD_W-1:0]  q_rx, q_ry, q_bx, q_by, q_cx, q_cy;
    logic               o_rx, o_ry, o_bx, o_by, o_cx, o_cy;

    // Signs and the near flag travel beside the dividers in a shift line.
    logic  side_valid_reg [DIV_STAGES];
    side_t side_reg       [DIV_STAGES];
    side_t side_in;
    side_t side_out;

    // Output register.
    logic     done_reg, done_next;
    jac_out_t result_reg, result_next;

    assign accept = start && !busy_reg;

    always_comb
    begin
        busy_next         = 1'b0;
        min_range_sq_next = cfg_wr_en ? cfg_wr_data : min_range_sq_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b1;
            min_range_sq_reg <= MIN_RANGE_SQ_RESET;
            in_valid_reg     <= 1'b0;
        end
        else
        begin
            busy_reg         <= busy_next;
            min_range_sq_reg <= min_range_sq_next;
            in_valid_reg     <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg <= state_vec;
    end

    rmj_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid_reg),
        .in_data      (in_reg),
        .min_range_sq (min_range_sq_reg),
        .out_valid    (front_valid),
        .out_data     (front_data)
    );

    rmj_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (root_valid),
        .out_data  (root_side),
        .out_root  (root)
    );

    rmj_prod u_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (root_valid),
        .in_data   (root_side),
        .in_root   (root),
        .out_valid (prod_valid),
        .out_data  (prod)
    );

    // The six distinct entries are each one quotient of scaled magnitudes.
    assign num_rx = {prod.side.mag_x, {FRAC_BITS{1'b0}}};
    assign num_ry = {prod.side.mag_y, {FRAC_BITS{1'b0}}};
    assign num_bx = {prod.side.mag_x, {(2 * FRAC_BITS){1'b0}}};
    assign num_by = {prod.side.mag_y, {(2 * FRAC_BITS){1'b0}}};
    assign num_cx = {prod.num_x3, {FRAC_BITS{1'b0}}};
    assign num_cy = {prod.num_y3, {FRAC_BITS{1'b0}}};

    rmj_div #(.NUM_W(NUM_R_W), .DEN_W(ROOT_W)) u_div_rx (
        .clk (clk), .num (num_rx), .den (prod.root), .quo (q_rx), .ovf (o_rx)
    );

    rmj_div #(.NUM_W(NUM_R_W), .DEN_W(ROOT_W)) u_div_ry (
        .clk (clk), .num (num_ry), .den (prod.root), .quo (q_ry), .ovf (o_ry)
    );

    rmj_div #(.NUM_W(NUM_B_W), .DEN_W(SUM_W)) u_div_bx (
        .clk (clk), .num (num_bx), .den (prod.side.sum_sq), .quo (q_bx), .ovf (o_bx)
    );

    rmj_div #(.NUM_W(NUM_B_W), .DEN_W(SUM_W)) u_div_by (
        .clk (clk), .num (num_by), .den (prod.side.sum_sq), .quo (q_by), .ovf (o_by)
    );

    rmj_div #(.NUM_W(NUM_C_W), .DEN_W(WIDE_W)) u_div_cx (
        .clk (clk), .num (num_cx), .den (prod.rho_cube), .quo (q_cx), .ovf (o_cx)
    );

    rmj_div #(.NUM_W(NUM_C_W), .DEN_W(WIDE_W)) u_div_cy (
        .clk (clk), .num (num_cy), .den (prod.rho_cube), .quo (q_cy), .ovf (o_cy)
    );

    always_comb
    begin
        side_in.neg_x = prod.side.neg_x;
        side_in.neg_y = prod.side.neg_y;
        side_in.neg_d = prod.side.neg_d;
        side_in.near  = prod.side.near;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
                side_valid_reg[i] <= 1'b0;
        end
        else
        begin
            side_valid_reg[0] <= prod_valid;
            for (int i = 1; i < DIV_STAGES; i++)
                side_valid_reg[i] <= side_valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_in;
        for (int i = 1; i < DIV_STAGES; i++)
            side_reg[i] <= side_reg[i-1];
    end

    assign side_out = side_reg[DIV_STAGES-1];

    // Apply signs and saturate; near the origin every entry is forced to zero.
    always_comb
    begin
        done_next = side_valid_reg[DIV_STAGES-1];
        if (side_out.near)
        begin
            result_next             = '0;
            result_next.near_origin = 1'b1;
        end
        else
        begin
            result_next.range_by_px   = sat_q(side_out.neg_x, q_rx, o_rx);
            result_next.range_by_py   = sat_q(side_out.neg_y, q_ry, o_ry);
            result_next.bearing_by_px = sat_q(!side_out.neg_y, q_by, o_by);
            result_next.bearing_by_py = sat_q(side_out.neg_x, q_bx, o_bx);
            result_next.rate_by_px    = sat_q(side_out.neg_y != side_out.neg_d, q_cy, o_cy);
            result_next.rate_by_py    = sat_q(side_out.neg_x == side_out.neg_d, q_cx, o_cx);
            result_next.near_origin   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign jacobian = result_reg;

endmodule

### design/rmj_front.sv
// ----------------------------------------------------------------------------
// Radar Jacobian front end
// Magnitudes, squares, range squared, the cross term and the near-origin test.
// ----------------------------------------------------------------------------
module rmj_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  rmj_pkg::jac_in_t              in_data,
    input  logic [rmj_pkg::WORD_W-1:0]    min_range_sq,
    output logic                          out_valid,
    output rmj_pkg::front_t               out_data
);
    import rmj_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] mx;
        logic [WORD_W-1:0] my;
        logic [WORD_W-1:0] mvx;
        logic [WORD_W-1:0] mvy;
        logic              nx;
        logic              ny;
        logic              na;
        logic              nb;
    } s1_t;

    typedef struct packed {
        logic [WORD_W-1:0] mx;
        logic [WORD_W-1:0] my;
        logic              nx;
        logic              ny;
        logic              na;
        logic              nb;
        logic [SUM_W-1:0]  sqx;
        logic [SUM_W-1:0]  sqy;
        logic [SUM_W-1:0]  pa;
        logic [SUM_W-1:0]  pb;
    } s2_t;

    typedef struct packed {
        logic [WORD_W-1:0]       mx;
        logic [WORD_W-1:0]       my;
        logic                    nx;
        logic                    ny;
        logic [SUM_W-1:0]        sum;
        logic signed [SUM_W:0]   ta;
        logic signed [SUM_W:0]   tb;
    } s3_t;

    typedef struct packed {
        logic [WORD_W-1:0]       mx;
        logic [WORD_W-1:0]       my;
        logic                    nx;
        logic                    ny;
        logic [SUM_W-1:0]        sum;
        logic                    near;
        logic signed [SUM_W:0]   diff;
    } s4_t;

    s1_t    s1_reg, s1_next;
    s2_t    s2_reg, s2_next;
    s3_t    s3_reg, s3_next;
    s4_t    s4_reg, s4_next;
    front_t s5_reg, s5_next;
    logic [FRONT_STAGES-1:0] valid_reg;

    always_comb
    begin
        s1_next.nx  = in_data.pos_x[WORD_W-1];
        s1_next.ny  = in_data.pos_y[WORD_W-1];
        s1_next.mx  = s1_next.nx ? WORD_W'(-in_data.pos_x) : WORD_W'(in_data.pos_x);
        s1_next.my  = s1_next.ny ? WORD_W'(-in_data.pos_y) : WORD_W'(in_data.pos_y);
        s1_next.mvx = in_data.vel_x[WORD_W-1] ? WORD_W'(-in_data.vel_x)
                                             : WORD_W'(in_data.vel_x);
        s1_next.mvy = in_data.vel_y[WORD_W-1] ? WORD_W'(-in_data.vel_y)
                                             : WORD_W'(in_data.vel_y);
        s1_next.na  = in_data.vel_x[WORD_W-1] ^ in_data.pos_y[WORD_W-1];
        s1_next.nb  = in_data.vel_y[WORD_W-1] ^ in_data.pos_x[WORD_W-1];
    end

    always_comb
    begin
        s2_next.mx  = s1_reg.mx;
        s2_next.my  = s1_reg.my;
        s2_next.nx  = s1_reg.nx;
        s2_next.ny  = s1_reg.ny;
        s2_next.na  = s1_reg.na;
        s2_next.nb  = s1_reg.nb;
        s2_next.sqx = SUM_W'(s1_reg.mx) * SUM_W'(s1_reg.mx);
        s2_next.sqy = SUM_W'(s1_reg.my) * SUM_W'(s1_reg.my);
        s2_next.pa  = SUM_W'(s1_reg.mvx) * SUM_W'(s1_reg.my);
        s2_next.pb  = SUM_W'(s1_reg.mvy) * SUM_W'(s1_reg.mx);
    end

    always_comb
    begin
        s3_next.mx  = s2_reg.mx;
        s3_next.my  = s2_reg.my;
        s3_next.nx  = s2_reg.nx;
        s3_next.ny  = s2_reg.ny;
        s3_next.sum = s2_reg.sqx + s2_reg.sqy;
        s3_next.ta  = s2_reg.na ? -$signed({1'b0, s2_reg.pa}) : $signed({1'b0, s2_reg.pa});
        s3_next.tb  = s2_reg.nb ? -$signed({1'b0, s2_reg.pb}) : $signed({1'b0, s2_reg.pb});
    end

    always_comb
    begin
        s4_next.mx   = s3_reg.mx;
        s4_next.my   = s3_reg.my;
        s4_next.nx   = s3_reg.nx;
        s4_next.ny   = s3_reg.ny;
        s4_next.sum  = s3_reg.sum;
        s4_next.near = (s3_reg.sum == '0)
                       || (s3_reg.sum < {{(SUM_W-WORD_W){1'b0}}, min_range_sq});
        s4_next.diff = s3_reg.ta - s3_reg.tb;
    end

    always_comb
    begin
        s5_next.mag_x  = s4_reg.mx;
        s5_next.mag_y  = s4_reg.my;
        s5_next.neg_x  = s4_reg.nx;
        s5_next.neg_y  = s4_reg.ny;
        s5_next.neg_d  = s4_reg.diff[SUM_W];
        s5_next.near   = s4_reg.near;
        s5_next.sum_sq = s4_reg.sum;
        s5_next.mag_d  = s4_reg.diff[SUM_W] ? SUM_W'(-s4_reg.diff) : SUM_W'(s4_reg.diff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[FRONT_STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
        s3_reg <= s3_next;
        s4_reg <= s4_next;
        s5_reg <= s5_next;
    end

    assign out_valid = valid_reg[FRONT_STAGES-1];
    assign out_data  = s5_reg;

endmodule

### design/rmj_isqrt.sv
// ----------------------------------------------------------------------------
// Radar Jacobian pipelined square root
// Floor square root of range squared, one result bit per stage.
// ----------------------------------------------------------------------------
module rmj_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  rmj_pkg::front_t               in_data,
    output logic                          out_valid,
    output rmj_pkg::front_t               out_data,
    output logic [rmj_pkg::ROOT_W-1:0]    out_root
);
    import rmj_pkg::*;

    localparam int N     = ROOT_STAGES;
    localparam int REM_W = ROOT_W + 2;

    logic              valid_reg [N];
    front_t            side_reg  [N];
    logic [REM_W-1:0]  rem_reg   [N];
    logic [ROOT_W-1:0] root_reg  [N];
    logic [SUM_W-1:0]  rad_reg   [N];

    genvar g;
    for (g = 0; g < N; g++)
    begin : g_stage
        logic              valid_prev;
        front_t            side_prev;
        logic [REM_W-1:0]  rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic [SUM_W-1:0]  rad_prev;
        logic [REM_W+1:0]  rem_shift;
        logic [REM_W+1:0]  trial;
        logic              fits;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;
        logic [SUM_W-1:0]  rad_next;

        if (g == 0)
        begin : g_head
            assign valid_prev = in_valid;
            assign side_prev  = in_data;
            assign rem_prev   = '0;
            assign root_prev  = '0;
            assign rad_prev   = in_data.sum_sq;
        end
        else
        begin : g_body
            assign valid_prev = valid_reg[g-1];
            assign side_prev  = side_reg[g-1];
            assign rem_prev   = rem_reg[g-1];
            assign root_prev  = root_reg[g-1];
            assign rad_prev   = rad_reg[g-1];
        end

        always_comb
        begin
            rem_shift = {rem_prev, rad_prev[SUM_W-1 -: 2]};
            trial     = (REM_W+2)'({root_prev, 2'b01});
            fits      = rem_shift >= trial;
            rem_next  = fits ? REM_W'(rem_shift - trial) : REM_W'(rem_shift);
            root_next = {root_prev[ROOT_W-2:0], fits};
            rad_next  = rad_prev << 2;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[g] <= 1'b0;
            else
                valid_reg[g] <= valid_prev;
        end

        always_ff @(posedge clk)
        begin
            side_reg[g] <= side_prev;
            rem_reg[g]  <= rem_next;
            root_reg[g] <= root_next;
            rad_reg[g]  <= rad_next;
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_data  = side_reg[N-1];
    assign out_root  = root_reg[N-1];

endmodule

### design/rmj_prod.sv
// ----------------------------------------------------------------------------
// Radar Jacobian product stages
// Forms rho cubed and the two range-rate numerators from 32-bit partials.
// ----------------------------------------------------------------------------
module rmj_prod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  rmj_pkg::front_t               in_data,
    input  logic [rmj_pkg::ROOT_W-1:0]    in_root,
    output logic                          out_valid,
    output rmj_pkg::prod_t                out_data
);
    import rmj_pkg::*;

    typedef struct packed {
        front_t            side;
        logic [ROOT_W-1:0] root;
        logic [SUM_W-1:0]  r_lo;
        logic [SUM_W-1:0]  r_hi;
        logic [SUM_W-1:0]  x_lo;
        logic [SUM_W-1:0]  x_hi;
        logic [SUM_W-1:0]  y_lo;
        logic [SUM_W-1:0]  y_hi;
    } part_t;

    part_t part_reg, part_next;
    prod_t prod_reg, prod_next;
    logic [PROD_STAGES-1:0] valid_reg;

    always_comb
    begin
        part_next.side = in_data;
        part_next.root = in_root;
        part_next.r_lo = SUM_W'(in_data.sum_sq[WORD_W-1:0]) * SUM_W'(in_root);
        part_next.r_hi = SUM_W'(in_data.sum_sq[SUM_W-1:WORD_W]) * SUM_W'(in_root);
        part_next.x_lo = SUM_W'(in_data.mag_x) * SUM_W'(in_data.mag_d[WORD_W-1:0]);
        part_next.x_hi = SUM_W'(in_data.mag_x) * SUM_W'(in_data.mag_d[SUM_W-1:WORD_W]);
        part_next.y_lo = SUM_W'(in_data.mag_y) * SUM_W'(in_data.mag_d[WORD_W-1:0]);
        part_next.y_hi = SUM_W'(in_data.mag_y) * SUM_W'(in_data.mag_d[SUM_W-1:WORD_W]);
    end

    always_comb
    begin
        prod_next.side     = part_reg.side;
        prod_next.root     = part_reg.root;
        prod_next.rho_cube = (WIDE_W'(part_reg.r_hi) << WORD_W) + WIDE_W'(part_reg.r_lo);
        prod_next.num_x3   = (WIDE_W'(part_reg.x_hi) << WORD_W) + WIDE_W'(part_reg.x_lo);
        prod_next.num_y3   = (WIDE_W'(part_reg.y_hi) << WORD_W) + WIDE_W'(part_reg.y_lo);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[PROD_STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
        prod_reg <= prod_next;
    end

    assign out_valid = valid_reg[PROD_STAGES-1];
    assign out_data  = prod_reg;

endmodule

### design/rmj_div.sv
// ----------------------------------------------------------------------------
// Radar Jacobian pipelined divider
// Unsigned restoring division, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module rmj_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
) (
    input  logic                        clk,
    input  logic [NUM_W-1:0]            num,
    input  logic [DEN_W-1:0]            den,
    output logic [rmj_pkg::WORD_W-1:0]  quo,
    output logic                        ovf
);
    import rmj_pkg::*;

    localparam int QW = WORD_W;
    localparam int HW = NUM_W - QW;
    localparam int CW = (HW > DEN_W) ? HW : DEN_W;

    logic [DEN_W-1:0] rem_reg [QW+1];
    logic [QW-1:0]    low_reg [QW+1];
    logic [QW-1:0]    quo_reg [QW+1];
    logic [DEN_W-1:0] den_reg [QW+1];
    logic             ovf_reg [QW+1];

    logic [CW-1:0]    head_ext;
    logic [CW-1:0]    den_ext;
    logic             ovf_next;
    logic [DEN_W-1:0] rem_head_next;

    // The quotient overflows 32 bits exactly when the top part is not below den.
    always_comb
    begin
        head_ext      = CW'(num[NUM_W-1:QW]);
        den_ext       = CW'(den);
        ovf_next      = head_ext >= den_ext;
        rem_head_next = ovf_next ? '0 : head_ext[DEN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= rem_head_next;
        low_reg[0] <= num[QW-1:0];
        quo_reg[0] <= '0;
        den_reg[0] <= den;
        ovf_reg[0] <= ovf_next;
    end

    genvar g;
    for (g = 1; g <= QW; g++)
    begin : g_step
        logic [DEN_W:0]   trial;
        logic             fits;
        logic [DEN_W:0]   diff;
        logic [DEN_W-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[g-1], low_reg[g-1][QW-1]};
            fits     = trial >= {1'b0, den_reg[g-1]};
            diff     = trial - {1'b0, den_reg[g-1]};
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g] <= rem_next;
            low_reg[g] <= low_reg[g-1] << 1;
            quo_reg[g] <= {quo_reg[g-1][QW-2:0], fits};
            den_reg[g] <= den_reg[g-1];
            ovf_reg[g] <= ovf_reg[g-1];
        end
    end

    assign quo = quo_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule

### design/rmj_checker.sv
// ----------------------------------------------------------------------------
// Radar Jacobian port checker
// Watches the top-level ports for latency, zeroing and sign consistency.
// ----------------------------------------------------------------------------
`include "radar_measurement_jacobian_macros.svh"

module rmj_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input rmj_pkg::jac_in_t     state_vec,
    input logic                 done,
    input rmj_pkg::jac_out_t    jacobian
);
    import rmj_pkg::*;

    logic near_beat;
    logic all_zero;
    logic px_negative;

    assign near_beat   = done && jacobian.near_origin;
    assign all_zero    = (jacobian.range_by_px == '0) && (jacobian.range_by_py == '0)
                         && (jacobian.bearing_by_px == '0) && (jacobian.bearing_by_py == '0)
                         && (jacobian.rate_by_px == '0) && (jacobian.rate_by_py == '0);
    assign px_negative = done && !jacobian.near_origin && jacobian.range_by_px[WORD_W-1];

    // Once ready after reset, the block stays ready.
    `RMJ_ASSERT_NEXT(a_ready_holds, clk, rst_n, !busy, !busy)

    // Every result beat belongs to an item taken a fixed number of edges earlier.
    `RMJ_ASSERT_IMPLY(a_done_has_item, clk, rst_n, done, $past(start && !busy, PIPE_DEPTH))

    // A near-origin result carries six zero entries.
    `RMJ_ASSERT_IMPLY(a_near_zero, clk, rst_n, near_beat, all_zero)

    // A negative px over rho can only come from a negative position x.
    `RMJ_ASSERT_IMPLY(a_sign_px, clk, rst_n, px_negative, $past(state_vec.pos_x[WORD_W-1], PIPE_DEPTH))

endmodule

bind radar_measurement_jacobian rmj_checker u_rmj_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .state_vec (state_vec),
    .done      (done),
    .jacobian  (jacobian)
);

### sim/tb_radar_measurement_jacobian.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radar measurement Jacobian testbench
// Drives state beats with random gaps and checks each Jacobian beat, field by
// field, against an in-bench fixed-point prediction. It also steps the
// near-origin threshold through several values, the extremes among them.
// ----------------------------------------------------------------------------
module tb_radar_measurement_jacobian;

    import rmj_pkg::*;

    localparam int FRAC = 16;
    // Edges from acceptance to result; the final wait adds slack to it.
    localparam int LATENCY = 74;

    // ------------------------------------------------------------------------
    // Jacobian scoreboard: predicts one result beat per accepted state beat and
    // compares the delivered beats, in order, with those predictions.
    // ------------------------------------------------------------------------
    class jacobian_scoreboard;
        logic [31:0] threshold;
        jac_out_t    pending[$];
        int          mismatches;

        function new();
            threshold  = MIN_RANGE_SQ_RESET;
            mismatches = 0;
        endfunction

        // Integer square root, rounded down.
        function automatic logic [63:0] floor_root(logic [63:0] v);
            logic [63:0] res;
            logic [63:0] bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        // Truncated quotient of magnitudes, then clamped to the signed word.
        function automatic logic [31:0] clamp_quot(logic neg, logic [127:0] num,
                                                   logic [127:0] den);
            logic [127:0] q;
            q = num / den;
            if (neg)
                return (q >= 128'h8000_0000) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
            return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        endfunction

        function void note_state(jac_in_t s);
            jac_out_t           e;
            logic               nx, ny, nvx, nvy, nd;
            logic [31:0]        mx, my, mvx, mvy;
            logic [63:0]        sum_sq, rho, md;
            logic signed [66:0] cross_a, cross_b, diff;
            logic [127:0]       rho_cube;

            nx  = s.pos_x[31];
            ny  = s.pos_y[31];
            nvx = s.vel_x[31];
            nvy = s.vel_y[31];
            mx  = nx  ? -s.pos_x : s.pos_x;
            my  = ny  ? -s.pos_y : s.pos_y;
            mvx = nvx ? -s.vel_x : s.vel_x;
            mvy = nvy ? -s.vel_y : s.vel_y;
            e = '0;
            sum_sq = 64'(mx) * 64'(mx) + 64'(my) * 64'(my);
            if (sum_sq == 0 || sum_sq < 64'(threshold))
            begin
                // Too close to the radar: all entries are forced to zero.
                e.near_origin = 1'b1;
            end
            else
            begin
                rho = floor_root(sum_sq);
                // Cross term vx*py - vy*px, each product signed by its factors.
                cross_a = 67'(64'(mvx) * 64'(my));
                if (nvx != ny)
                    cross_a = -cross_a;
                cross_b = 67'(64'(mvy) * 64'(mx));
                if (nvy != nx)
                    cross_b = -cross_b;
                nd   = cross_a < cross_b;
                diff = cross_a - cross_b;
                md   = nd ? 64'(-diff) : 64'(diff);
                rho_cube = 128'(sum_sq) * 128'(rho);

                e.range_by_px   = clamp_quot(nx, 128'(mx) << FRAC, 128'(rho));
                e.range_by_py   = clamp_quot(ny, 128'(my) << FRAC, 128'(rho));
                e.bearing_by_px = clamp_quot(!ny, 128'(my) << (2 * FRAC), 128'(sum_sq));
                e.bearing_by_py = clamp_quot(nx, 128'(mx) << (2 * FRAC), 128'(sum_sq));
                e.rate_by_px    = clamp_quot(ny != nd,
                                             (128'(my) * 128'(md)) << FRAC, rho_cube);
                e.rate_by_py    = clamp_quot(nx == nd,
                                             (128'(mx) * 128'(md)) << FRAC, rho_cube);
            end
            pending.push_back(e);
        endfunction

        function void report_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on %s: expected %h, got %h", field, exp_v, act_v);
            end
        endfunction

        function void check_result(jac_out_t got);
            jac_out_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", got);
                return;
            end
            e = pending.pop_front();
            report_field("range_by_px", e.range_by_px, got.range_by_px);
            report_field("range_by_py", e.range_by_py, got.range_by_py);
            report_field("bearing_by_px", e.bearing_by_px, got.bearing_by_px);
            report_field("bearing_by_py", e.bearing_by_py, got.bearing_by_py);
            report_field("rate_by_px", e.rate_by_px, got.rate_by_px);
            report_field("rate_by_py", e.rate_by_py, got.rate_by_py);
            report_field("near_origin", 32'(e.near_origin), 32'(got.near_origin));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    jac_in_t     state_vec;
    logic        done;
    jac_out_t    jacobian;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    jacobian_scoreboard board;
    // When set, the sender offers beats back to back with no gaps.
    bit          back_to_back;

    radar_measurement_jacobian #(.FRAC_BITS(FRAC)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .state_vec   (state_vec),
        .done        (done),
        .jacobian    (jacobian),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result beats are taken at the rising edge that ends their single cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(jacobian);
    end

    // Offers one state beat after a random gap and holds it until taken.
    // Inputs change only at falling edges; with no gap, start is lowered and
    // raised again within the same time step, so it stays high between beats.
    task automatic send_state(jac_in_t s);
        int gap;
        gap = back_to_back ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     = 1'b1;
        state_vec = s;
        forever
        begin
            @(posedge clk);
            if (!busy)
            begin
                board.note_state(s);
                break;
            end
        end
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic send_xy(logic [31:0] px, logic [31:0] py, logic [31:0] vx,
                           logic [31:0] vy);
        jac_in_t s;
        s.pos_x = px;
        s.pos_y = py;
        s.vel_x = vx;
        s.vel_y = vy;
        send_state(s);
    endtask

    task automatic wait_drained();
        while (board.pending.size() != 0)
            @(negedge clk);
    endtask

    // The threshold is only rewritten while nothing is in flight.
    task automatic write_threshold(logic [31:0] value);
        wait_drained();
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(posedge clk);
        board.threshold = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // One random coordinate, half the time of moderate size so the quotients stay
    // in range, with some small values and some spanning the whole word.
    function automatic logic [31:0] pick_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return $urandom();
        if (sel < 5)
            return 32'($signed($urandom_range(0, 64)) - 32);
        if (sel < 8)
            return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        return 32'($signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
    endfunction

    task automatic random_run(int count);
        repeat (count)
        begin
            // Now and then switch between gapped and back-to-back stretches.
            if ($urandom_range(0, 49) == 0)
                back_to_back = !back_to_back;
            send_xy(pick_coord(), pick_coord(), pick_coord(), pick_coord());
        end
        back_to_back = 1'b0;
    endtask

    initial
    begin
        #2_000_000;
        $display("radar_measurement_jacobian regression: fail");
        $finish;
    end

    initial
    begin
        board        = new();
        back_to_back = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        state_vec    = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed beats under the reset threshold.
        send_xy(32'h0, 32'h0, 32'h0001_0000, 32'h0);            // exact origin
        send_xy(32'd1, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000);    // below threshold
        send_xy(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000);    // on the x axis
        send_xy(32'h0, 32'hFFFF_0000, 32'h0001_0000, 32'h0);    // on the -y axis
        send_xy(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_xy(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_xy(32'h8000_0000, 32'h0, 32'h0, 32'h8000_0000);
        send_xy(32'h0003_0000, 32'hFFFC_0000, 32'hFFFE_0000, 32'h0005_0000);
        send_xy(32'h0000_0100, 32'h0000_0100, 32'h7FFF_FFFF, 32'h8000_0000);
        // Range squared just above and just below the default threshold.
        send_xy(32'd656, 32'd0, 32'h1234_5678, 32'h8765_4321);
        send_xy(32'd655, 32'd0, 32'h1234_5678, 32'h8765_4321);

        // A zero threshold: only the exact origin counts as near, and tiny
        // positions drive the bearing and rate entries into saturation.
        write_threshold(32'h0);
        send_xy(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_xy(32'd1, 32'h0, 32'h0, 32'h7FFF_FFFF);
        send_xy(32'hFFFF_FFFF, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_xy(32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        random_run(500);

        // The largest threshold: near unless range squared reaches 2^32 - 1.
        write_threshold(32'hFFFF_FFFF);
        send_xy(32'h0000_FFFF, 32'h0, 32'h1, 32'h1);
        send_xy(32'h0001_0000, 32'h0, 32'h1, 32'h1);
        random_run(300);

        write_threshold($urandom());
        random_run(500);

        write_threshold(MIN_RANGE_SQ_RESET);
        random_run(700);

        wait_drained();
        repeat (LATENCY + 10) @(negedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("radar_measurement_jacobian regression: pass");
        else
            $display("radar_measurement_jacobian regression: fail");
        $finish;
    end

endmodule
